/* sv/spot_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spot_pkg
// Shared widths, codes and controller/datapath types for the peak onset trigger.
// ----------------------------------------------------------------------------
package spot_pkg;

    localparam int AmpW      = 16;
    localparam int CountW    = 16;
    localparam int StrW      = 14;
    localparam int CfgIdxW   = 8;
    localparam int CfgDataW  = 16;
    localparam int FracW     = 12;
    localparam int Q12One    = 4096;
    localparam int RunMaxRst = 6144;
    localparam int LevelRst  = 2048;
    localparam int HoldRst   = 100;

    // dividend is |peak - level| << 12 plus half the divisor
    localparam int DivW      = AmpW + FracW + 1;
    localparam int DivSteps  = DivW;
    localparam int StepCntW  = $clog2(DivSteps);

    localparam logic OpBin  = 1'b0;
    localparam logic OpTick = 1'b1;

    localparam logic [CfgIdxW-1:0] RegTriggerLevel = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] RegHoldoffTicks = CfgIdxW'(1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } t_state;

    typedef struct packed {
        logic accept_en;
        logic div_step;
        logic div_last;
    } t_cmd;

    typedef struct packed {
        logic div_start;
    } t_status;

endpackage

/* sv/spot_bin_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spot_bin_if
// Input channel: spectrum bin words and tick words.
// ----------------------------------------------------------------------------
interface spot_bin_if;
    import spot_pkg::*;

    logic            valid;
    logic            ready;
    logic            operation;
    logic [AmpW-1:0] amplitude;
    logic            last_bin;

    modport source (output valid, output operation, output amplitude, output last_bin,
                    input ready);
    modport sink   (input valid, input operation, input amplitude, input last_bin,
                    output ready);
endinterface

/* sv/spot_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spot_res_if
// Result channel: one word per finished frame.
// ----------------------------------------------------------------------------
interface spot_res_if;
    import spot_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [AmpW-1:0]        frame_peak;
    logic                   fired;
    logic signed [StrW-1:0] strength;

    modport source (output valid, output frame_peak, output fired, output strength,
                    input ready);
    modport sink   (input valid, input frame_peak, input fired, input strength,
                    output ready);
endinterface

/* sv/spot_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spot_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface spot_cfg_if;
    import spot_pkg::*;

    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/spot_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spot_ctrl
// Controller: admits words while idle and sequences the strength divider.
// ----------------------------------------------------------------------------
module spot_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spot_pkg::t_status i_status,
    output spot_pkg::t_cmd    o_cmd
);
    import spot_pkg::*;

    t_state              r_state, n_state;
    logic [StepCntW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept_en = 1'b1;
                if (i_status.div_start) begin
                    n_state = ST_DIV;
                    n_cnt   = '0;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == StepCntW'(DivSteps - 1)) begin
                    o_cmd.div_last = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* sv/spot_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spot_dp
// Datapath: frame peak tracking, trigger decision, hold-off, serial divider
// and the result register.
// ----------------------------------------------------------------------------
module spot_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spot_pkg::t_cmd    i_cmd,
    output spot_pkg::t_status o_status,
    spot_bin_if.sink          i_bin,
    spot_res_if.source        o_res,
    spot_cfg_if.sink          i_cfg
);
    import spot_pkg::*;

    // configuration and tracking state
    logic [AmpW-1:0]   r_trig_level;
    logic [CountW-1:0] r_hold_ticks;
    logic [AmpW-1:0]   r_frame_max;
    logic [AmpW-1:0]   r_prev_peak;
    logic [AmpW-1:0]   r_running_max;
    logic [CountW-1:0] r_hold_count;

    // divider
    logic [AmpW-1:0]   r_rem;
    logic [DivW-1:0]   r_quo;
    logic [AmpW-1:0]   r_den;
    logic              r_neg;
    logic [AmpW-1:0]   r_div_peak;

    // result register
    logic                   r_out_valid, n_out_valid;
    logic [AmpW-1:0]        r_out_peak;
    logic                   r_out_fired;
    logic signed [StrW-1:0] r_out_strength;

    logic            frame_end, out_free, bin_ready, accept;
    logic [AmpW-1:0] peak, top, mag, den;
    logic            fire, neg, need_div;
    logic [DivW-1:0] dividend;
    logic [AmpW:0]   rem_sh;
    logic            rem_ge;
    logic [AmpW-1:0] rem_next;
    logic [DivW-1:0] quo_next;
    logic [FracW:0]  q_sat;
    logic [StrW-1:0] div_strength;
    logic            load_direct;

    assign frame_end = (i_bin.operation == OpBin) && i_bin.last_bin;
    assign out_free  = !r_out_valid || o_res.ready;
    // a frame end needs room in the result register
    assign bin_ready = i_cmd.accept_en && (!frame_end || out_free);
    assign accept    = i_bin.valid && bin_ready;

    assign peak     = (i_bin.amplitude > r_frame_max) ? i_bin.amplitude : r_frame_max;
    assign top      = (peak > r_running_max) ? peak : r_running_max;
    assign fire     = (peak < r_prev_peak) && (r_prev_peak > r_trig_level) &&
                      (r_hold_count == '0);
    assign need_div = fire && (top > r_trig_level);
    assign neg      = peak < r_trig_level;
    assign mag      = neg ? (r_trig_level - peak) : (peak - r_trig_level);
    assign den      = top - r_trig_level;
    // round half away from zero on the magnitude
    assign dividend = {1'b0, mag, FracW'(0)} + DivW'(den >> 1);

    assign o_status.div_start = accept && frame_end && need_div;
    assign load_direct        = accept && frame_end && !need_div;

    // one restoring step per cycle
    assign rem_sh   = {r_rem, r_quo[DivW-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_den};
    assign rem_next = rem_ge ? AmpW'(rem_sh - {1'b0, r_den}) : AmpW'(rem_sh);
    assign quo_next = {r_quo[DivW-2:0], rem_ge};

    assign q_sat = (quo_next > DivW'(Q12One)) ? (FracW+1)'(Q12One) : quo_next[FracW:0];
    assign div_strength = r_neg ? StrW'(-{1'b0, q_sat}) : StrW'({1'b0, q_sat});

    assign i_bin.ready    = bin_ready;
    assign i_cfg.ready    = 1'b1;
    assign o_res.valid    = r_out_valid;
    assign o_res.frame_peak = r_out_peak;
    assign o_res.fired    = r_out_fired;
    assign o_res.strength = r_out_strength;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_level  <= AmpW'(LevelRst);
            r_hold_ticks  <= CountW'(HoldRst);
            r_frame_max   <= '0;
            r_prev_peak   <= '0;
            r_running_max <= AmpW'(RunMaxRst);
            r_hold_count  <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    RegTriggerLevel: r_trig_level <= i_cfg.data;
                    RegHoldoffTicks: r_hold_ticks <= i_cfg.data;
                    default: ;
                endcase
            end
            if (accept) begin
                if (i_bin.operation == OpTick) begin
                    if (r_hold_count != '0) begin
                        r_hold_count <= r_hold_count - 1'b1;
                    end
                end else if (i_bin.last_bin) begin
                    r_frame_max   <= '0;
                    r_prev_peak   <= peak;
                    r_running_max <= top;
                    if (fire) begin
                        r_hold_count <= r_hold_ticks;
                    end
                end else begin
                    r_frame_max <= peak;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_status.div_start) begin
            r_rem      <= '0;
            r_quo      <= dividend;
            r_den      <= den;
            r_neg      <= neg;
            r_div_peak <= peak;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_next;
            r_quo <= quo_next;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
        if (load_direct || i_cmd.div_last) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_direct) begin
            r_out_peak     <= peak;
            r_out_fired    <= fire;
            r_out_strength <= '0;
        end else if (i_cmd.div_last) begin
            r_out_peak     <= r_div_peak;
            r_out_fired    <= 1'b1;
            r_out_strength <= div_strength;
        end
    end

endmodule

/* sv/spectral_peak_onset_trigger.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_peak_onset_trigger
// Frame peak tracker with onset trigger, hold-off and trigger strength.
// ----------------------------------------------------------------------------
// i_bin carries bin words (operation 0, amplitude, last_bin) and tick words
// (operation 1). Bin and tick words are taken one per cycle while the divider
// is idle. The bin word with last_bin set closes a frame and loads one word
// into the o_res register: frame_peak, fired and strength in signed Q1.12.
// A frame that does not fire, or fires with an empty level range, gives its
// result in the cycle after the closing word. A firing frame runs a restoring
// divider, one quotient bit per cycle; the result shows once the last step is
// done, and i_bin is held off while the divider runs.
// While o_res is stalled, bin and tick words keep flowing; only a closing
// word waits until the result register is free.
// i_cfg writes trigger_level (index 0) and holdoff_ticks (index 1) and is
// always ready; other indexes are ignored.
// Reset (synchronous, active low) sets level 0.5, hold-off 100 ticks,
// running maximum 1.5, clears the frame state and empties the result register.
// ----------------------------------------------------------------------------
module spectral_peak_onset_trigger (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spot_bin_if.sink   i_bin,
    spot_res_if.source o_res,
    spot_cfg_if.sink   i_cfg
);
    import spot_pkg::*;

    t_cmd    cmd;
    t_status status;

    spot_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    spot_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_bin    (i_bin),
        .o_res    (o_res),
        .i_cfg    (i_cfg)
    );

endmodule

/* tb/sv/spectral_peak_onset_trigger_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_peak_onset_trigger_test
// Self-checking bench for the peak onset trigger. A short walk through a
// stimulus plan covers empty frames, ticks, hold-off suppression and
// saturated strength, then random phases stream well-formed frames with
// ticks and some noise under several level and hold-off settings. Every
// frame word is checked against a hand-given word or an in-bench trigger model.
// ----------------------------------------------------------------------------
module spectral_peak_onset_trigger_test;
    import spot_pkg::*;

    typedef struct {
        logic [AmpW-1:0]        peak;
        logic                   fired;
        logic signed [StrW-1:0] strength;
    } t_frame_word;

    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [CfgIdxW-1:0] reg_idx;
        logic               op;
        logic [AmpW-1:0]    amp;
        logic               last;
        bit                 typed;
        t_frame_word        want;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;

    spot_bin_if bin_ch ();
    spot_res_if res_ch ();
    spot_cfg_if cfg_ch ();

    spectral_peak_onset_trigger uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bin   (bin_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // trigger model state
    logic [AmpW-1:0]   level_m    = AmpW'(LevelRst);
    logic [CountW-1:0] holdoff_m  = CountW'(HoldRst);
    logic [AmpW-1:0]   frame_max_m = '0;
    logic [AmpW-1:0]   prev_peak_m = '0;
    logic [AmpW-1:0]   run_max_m   = AmpW'(RunMaxRst);
    logic [CountW-1:0] hold_cnt_m  = '0;

    t_frame_word pending_frames[$];
    t_plan_row   plan[$];
    int          mismatches = 0;
    bit          quiet_mode = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(10_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    // (peak - level) / (run_max - level) in Q1.12, half away from zero, saturated
    function automatic logic signed [StrW-1:0] onset_strength(input logic [AmpW-1:0] peak);
        longint num;
        longint den;
        longint mag;
        longint q;
        logic signed [StrW-1:0] s;
        if (run_max_m <= level_m) return '0;
        num = longint'(peak) - longint'(level_m);
        den = longint'(run_max_m) - longint'(level_m);
        mag = ((num < 0) ? -num : num) * longint'(Q12One);
        q = (mag + den / 2) / den;
        if (q > Q12One) q = Q12One;
        s = StrW'(q);
        return (num < 0) ? -s : s;
    endfunction

    function automatic bit track_word(input logic op, input logic [AmpW-1:0] amp,
                                      input logic last, output t_frame_word word);
        logic fire;
        word.peak = '0;
        word.fired = 1'b0;
        word.strength = '0;
        if (op == OpTick) begin
            if (hold_cnt_m > 0) hold_cnt_m = hold_cnt_m - 1'b1;
            return 1'b0;
        end
        if (amp > frame_max_m) frame_max_m = amp;
        if (!last) return 1'b0;
        word.peak = frame_max_m;
        if (word.peak > run_max_m) run_max_m = word.peak;
        fire = (word.peak < prev_peak_m) && (prev_peak_m > level_m) && (hold_cnt_m == 0);
        if (fire) begin
            hold_cnt_m = holdoff_m;
            word.strength = onset_strength(word.peak);
        end
        word.fired = fire;
        prev_peak_m = word.peak;
        frame_max_m = '0;
        return 1'b1;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (quiet_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [AmpW-1:0] pick_amp();
        int v;
        int d;
        d = $urandom_range(0, 1024);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: v = int'(level_m) + d - 512;
            4: v = int'(prev_peak_m) - d / 4;
            default: return AmpW'($urandom);
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return AmpW'(v);
    endfunction

    task automatic send_word(input logic op, input logic [AmpW-1:0] amp, input logic last,
                             input bit typed, input t_frame_word typed_word);
        t_frame_word word;
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            bin_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        bin_ch.valid = 1'b1;
        bin_ch.operation = op;
        bin_ch.amplitude = amp;
        bin_ch.last_bin = last;
        do @(posedge i_clk); while (!bin_ch.ready);
        if (track_word(op, amp, last, word)) pending_frames.push_back(typed ? typed_word : word);
    endtask

    // drains the expected frame words, then waits out any running divide
    task automatic wait_idle();
        @(negedge i_clk);
        bin_ch.valid = 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        wait_idle();
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == RegTriggerLevel) level_m = val;
        else if (idx == RegHoldoffTicks) holdoff_m = val;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic plan_word(input logic op, input logic [AmpW-1:0] amp, input logic last);
        t_plan_row row;
        row.kind = ROW_WORD;
        row.reg_idx = '0;
        row.op = op;
        row.amp = amp;
        row.last = last;
        row.typed = 1'b0;
        row.want.peak = '0;
        row.want.fired = 1'b0;
        row.want.strength = '0;
        plan.push_back(row);
    endtask

    // closing bin word whose frame word is known by hand
    task automatic plan_frame(input logic [AmpW-1:0] amp, input logic [AmpW-1:0] peak,
                              input logic fired, input logic signed [StrW-1:0] strength);
        plan_word(OpBin, amp, 1'b1);
        plan[plan.size() - 1].typed = 1'b1;
        plan[plan.size() - 1].want.peak = peak;
        plan[plan.size() - 1].want.fired = fired;
        plan[plan.size() - 1].want.strength = strength;
    endtask

    task automatic plan_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        plan_word(OpBin, val, 1'b0);
        plan[plan.size() - 1].kind = ROW_REG;
        plan[plan.size() - 1].reg_idx = idx;
    endtask

    task automatic random_phase(input logic [AmpW-1:0] lvl, input logic [CountW-1:0] hold,
                                input int n_words, input bit quiet);
        t_frame_word blank;
        int sent;
        int flen;
        blank.peak = '0;
        blank.fired = 1'b0;
        blank.strength = '0;
        write_reg(RegTriggerLevel, lvl);
        write_reg(RegHoldoffTicks, hold);
        quiet_mode = quiet;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 99) < 85) begin
                flen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
                for (int i = 0; i < flen; i++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_word(OpTick, AmpW'($urandom), 1'($urandom), 1'b0, blank);
                        sent++;
                    end
                    send_word(OpBin, pick_amp(), 1'(i == flen - 1), 1'b0, blank);
                    sent++;
                end
            end else begin
                send_word(1'($urandom), AmpW'($urandom), 1'($urandom), 1'b0, blank);
                sent++;
            end
        end
        quiet_mode = 1'b0;
    endtask

    // result side stalls
    initial begin
        int stall_left;
        res_ch.ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res_ch.ready = 1'b0;
                stall_left--;
            end else begin
                res_ch.ready = 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_frame_word want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_frames.size() == 0) begin
                $display("%0t: unexpected frame word, expected none, %s %0d fired %0d str %0d",
                         $time, "got peak", res_ch.frame_peak, res_ch.fired,
                         res_ch.strength);
                mismatches++;
            end else begin
                want = pending_frames.pop_front();
                if (res_ch.frame_peak !== want.peak) begin
                    $display("%0t: frame_peak expected %0d got %0d",
                             $time, want.peak, res_ch.frame_peak);
                    mismatches++;
                end
                if (res_ch.fired !== want.fired) begin
                    $display("%0t: fired expected %0d got %0d", $time, want.fired, res_ch.fired);
                    mismatches++;
                end
                if (res_ch.strength !== want.strength) begin
                    $display("%0t: strength expected %0d got %0d",
                             $time, want.strength, res_ch.strength);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        bin_ch.valid = 1'b0;
        bin_ch.operation = OpBin;
        bin_ch.amplitude = '0;
        bin_ch.last_bin = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty frame, tick at zero, then a first trigger with a one tick hold-off
        plan_frame(16'd0, 16'd0, 1'b0, '0);
        plan_word(OpTick, 16'hFFFF, 1'b1);
        plan_reg(RegHoldoffTicks, 16'd1);
        plan_word(OpBin, 16'hFFFF, 1'b0);
        plan_frame(16'h1234, 16'hFFFF, 1'b0, '0);
        plan_frame(16'd2048, 16'd2048, 1'b1, '0);
        plan_frame(16'd40000, 16'd40000, 1'b0, '0);
        plan_frame(16'd30000, 16'd30000, 1'b0, '0);
        plan_word(OpTick, 16'd0, 1'b0);
        plan_word(OpTick, 16'd0, 1'b0);
        // zero hold-off, peaks below level saturate negative
        plan_reg(RegHoldoffTicks, 16'd0);
        plan_reg(RegTriggerLevel, 16'd50000);
        plan_frame(16'd60000, 16'd60000, 1'b0, '0);
        plan_frame(16'd0, 16'd0, 1'b1, -14'sd4096);
        plan_frame(16'd60000, 16'd60000, 1'b0, '0);
        plan_word(OpBin, 16'd55000, 1'b0);
        plan_word(OpBin, 16'd1, 1'b0);
        plan_word(OpBin, 16'd54999, 1'b1);
        plan_frame(16'hFFFF, 16'hFFFF, 1'b0, '0);
        plan_word(OpBin, 16'd65534, 1'b1);
        // tick inside a frame keeps the frame max
        plan_word(OpBin, 16'd300, 1'b0);
        plan_word(OpTick, 16'd0, 1'b0);
        plan_frame(16'd200, 16'd300, 1'b1, -14'sd4096);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG)
                write_reg(plan[i].reg_idx, plan[i].amp);
            else
                send_word(plan[i].op, plan[i].amp, plan[i].last, plan[i].typed, plan[i].want);
        end

        random_phase(16'd0, 16'd0, 200, 1'b1);
        random_phase(16'hFFFF, 16'hFFFF, 200, 1'b0);
        random_phase(AmpW'($urandom), 16'd3, 200, 1'b0);
        random_phase(AmpW'(LevelRst), CountW'(HoldRst), 200, 1'b1);
        random_phase(AmpW'($urandom_range(0, 40000)), CountW'($urandom_range(0, 5)), 200, 1'b0);
        random_phase(16'd65534, 16'd1, 200, 1'b0);
        random_phase(AmpW'($urandom), CountW'($urandom_range(0, 8)), 200, 1'b0);

        wait_idle();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/spot_pkg.sv
sv/spot_bin_if.sv
sv/spot_res_if.sv
sv/spot_cfg_if.sv
sv/spot_ctrl.sv
sv/spot_dp.sv
sv/spectral_peak_onset_trigger.sv
tb/sv/spectral_peak_onset_trigger_test.sv
